// ===== sv/sad_pkg.sv =====
`timescale 1ns / 1ps
// sad_pkg: shared types and constants of the slot allocator with deferred release
// used by every module of the block, no dependencies of its own

package sad_pkg;

    localparam int SLOT_W      = 10;
    localparam int STAT_W      = 2;
    localparam int COUNT_W     = 10;
    localparam int FIFO_DEPTH  = 2;

    // operation codes of an input item
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_QFULL    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_RELEASE,
        K_ADVANCE,
        K_NONE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DRAIN
    } t_back_state;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SLOT_W-1:0] slot_in;
        logic              frame_index;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] free_count;
    } t_result;

    // classified command between the front and the back
    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic              frame;
    } t_cmd;

endpackage

// ===== sv/sad_fifo.sv =====
`timescale 1ns / 1ps
// sad_fifo: two-entry queue of opaque words, used for commands and for results
// depends on sad_pkg for the depth

module sad_fifo
    import sad_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [W-1:0]  r_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== sv/sad_front.sv =====
`timescale 1ns / 1ps
// sad_front: accepts input beats and classifies them into commands
// depends on sad_pkg for the item and command types

module sad_front
    import sad_pkg::*;
#(
    parameter int NUM_FRAMES = 2
) (
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_cmd_full,
    output logic  o_full,
    output logic  o_cmd_push,
    output t_cmd  o_cmd
);

    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;

    always_comb begin
        o_cmd.slot = i_item.slot_in;
        // frame index reduced modulo the frame count
        o_cmd.frame = (NUM_FRAMES > 1) ? i_item.frame_index : 1'b0;
        case (i_item.operation)
            OP_ALLOC:   o_cmd.kind = K_ALLOC;
            OP_RELEASE: o_cmd.kind = K_RELEASE;
            OP_ADVANCE: o_cmd.kind = K_ADVANCE;
            default:    o_cmd.kind = K_NONE;
        endcase
    end

endmodule

// ===== sv/sad_back.sv =====
`timescale 1ns / 1ps
// sad_back: executes commands against the free stack and the release queues
// depends on sad_pkg for command, result, status and state types

module sad_back
    import sad_pkg::*;
#(
    parameter int NUM_SLOTS   = 1024,
    parameter int NUM_FRAMES  = 2,
    parameter int QUEUE_DEPTH = 128
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int STACK_CAP = NUM_SLOTS - 1;
    localparam int SAW = (STACK_CAP > 1) ? $clog2(STACK_CAP) : 1;
    localparam int CW  = $clog2(STACK_CAP + 1);
    localparam int QTOT = NUM_FRAMES * QUEUE_DEPTH;
    localparam int QAW = (QTOT > 1) ? $clog2(QTOT) : 1;
    localparam int IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FLW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_low;
    logic [FLW-1:0]    r_fill [0:NUM_FRAMES-1];
    logic [FW-1:0]     r_cur;
    logic              r_next;
    logic [FLW-1:0]    r_idx;
    logic [FLW-1:0]    r_drain_n;
    logic              r_pend;
    logic              r_ovf;
    logic              r_use_rst;
    logic [SLOT_W-1:0] r_rst_val;
    logic [SLOT_W-1:0] r_stk_rdata;
    logic [SLOT_W-1:0] r_q_rdata;

    logic [SLOT_W-1:0] r_stack [0:STACK_CAP-1];
    logic [SLOT_W-1:0] r_queue [0:QTOT-1];

    logic           w_go;
    logic           w_stk_rd;
    logic           w_stk_wr;
    logic           w_q_rd;
    logic           w_q_wr;
    logic           w_done;
    logic [CW-1:0]  w_cnt_m1;
    logic [FLW-1:0] w_fill;
    logic           w_qfull;
    logic [QAW-1:0] w_qbase;

    assign w_go     = (r_state == S_IDLE) && !i_cmd_empty && !i_res_full;
    assign w_cnt_m1 = r_count - 1'b1;
    assign w_fill   = r_fill[r_cur];
    assign w_qfull  = (w_fill >= FLW'(QUEUE_DEPTH));
    assign w_qbase  = QAW'(QAW'(r_cur) * QAW'(QUEUE_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_go && i_cmd.kind == K_ALLOC && r_count != '0) begin
                    n_state = S_POP;
                end else if (w_go && i_cmd.kind == K_ADVANCE) begin
                    n_state = S_DRAIN;
                end
            end
            S_POP:   n_state = S_IDLE;
            S_DRAIN: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory strobes
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.slot_out   = '0;
        o_res.status     = ST_OK;
        o_res.free_count = COUNT_W'(r_count);
        w_stk_rd = 1'b0;
        w_stk_wr = 1'b0;
        w_q_rd   = 1'b0;
        w_q_wr   = 1'b0;
        w_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_go) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        K_ALLOC: begin
                            if (r_count == '0) begin
                                o_res_push   = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                w_stk_rd = 1'b1;
                            end
                        end
                        K_RELEASE: begin
                            o_res_push = 1'b1;
                            if (w_qfull) begin
                                o_res.status = ST_QFULL;
                            end else begin
                                w_q_wr = 1'b1;
                            end
                        end
                        K_ADVANCE: ;
                        default: o_res_push = 1'b1;
                    endcase
                end
            end
            S_POP: begin
                o_res_push     = 1'b1;
                o_res.slot_out = r_use_rst ? r_rst_val : r_stk_rdata;
            end
            S_DRAIN: begin
                // read stage feeds the push stage in the following cycle
                w_stk_wr = r_pend && (r_count < CW'(STACK_CAP));
                w_q_rd   = (r_idx < r_drain_n);
                w_done   = !r_pend && !w_q_rd;
                if (w_done) begin
                    o_res_push   = 1'b1;
                    o_res.status = r_ovf ? ST_OVERFLOW : ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(STACK_CAP);
            r_low   <= CW'(STACK_CAP);
            r_cur   <= '0;
            r_pend  <= 1'b0;
            for (int f = 0; f < NUM_FRAMES; f++) begin
                r_fill[f] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_stk_rd) begin
                r_count <= w_cnt_m1;
                // low-water mark: below it the stack still holds its reset contents
                if (r_count == r_low) begin
                    r_low <= w_cnt_m1;
                end
            end
            if (w_q_wr) begin
                r_fill[r_cur] <= w_fill + 1'b1;
            end
            if (r_state == S_DRAIN) begin
                r_pend <= w_q_rd;
                if (w_stk_wr) begin
                    r_count <= r_count + 1'b1;
                end
                if (w_done) begin
                    r_fill[r_cur] <= '0;
                    r_cur         <= FW'(r_next);
                end
            end
            if (w_go && i_cmd.kind == K_ADVANCE) begin
                r_pend <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_stk_rd) begin
            r_use_rst <= (r_count == r_low);
            r_rst_val <= SLOT_W'(NUM_SLOTS) - SLOT_W'(r_count);
        end
        if (w_go && i_cmd.kind == K_ADVANCE) begin
            r_drain_n <= w_fill;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_next    <= i_cmd.frame;
        end
        if (r_state == S_DRAIN) begin
            if (w_q_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend && !w_stk_wr) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (w_stk_wr) begin
            r_stack[r_count[SAW-1:0]] <= r_q_rdata;
        end
        if (w_stk_rd) begin
            r_stk_rdata <= r_stack[w_cnt_m1[SAW-1:0]];
        end
    end

    // release queue memory
    always_ff @(posedge i_clk) begin
        if (w_q_wr) begin
            r_queue[w_qbase + QAW'(w_fill[IW-1:0])] <= i_cmd.slot;
        end
        if (w_q_rd) begin
            r_q_rdata <= r_queue[w_qbase + QAW'(r_idx[IW-1:0])];
        end
    end

endmodule

// ===== sv/slot_allocator_deferred_release.sv =====
`timescale 1ns / 1ps
// slot_allocator_deferred_release: top level, front classifier, command queue,
// back executor and result queue; depends on sad_pkg, sad_front, sad_fifo and sad_back
//
//  channel   ports                      beat taken when
//  input     push, full, i_item         push && !full
//  result    empty, pop, o_result       pop && !empty
//
// each input beat passes the command queue and gives exactly one result beat
// back steps: allocate reads the free stack through a registered read, then returns the handle;
// an allocate on an empty stack, a release and the unused code return at once; advance
// drains one queued handle per cycle through the queue read and stack write ports
// synchronous reset; a low-water mark stands in for the stack's reset contents
// the back waits while the result queue is full, the front while the command queue is full

module slot_allocator_deferred_release
    import sad_pkg::*;
#(
    parameter int NUM_SLOTS   = 1024,
    parameter int NUM_FRAMES  = 2,
    parameter int QUEUE_DEPTH = 128
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic    w_cmd_push;
    logic    w_cmd_full;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res;

    sad_front #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_front (
        .i_push    (push),
        .i_item    (i_item),
        .i_cmd_full(w_cmd_full),
        .o_full    (full),
        .o_cmd_push(w_cmd_push),
        .o_cmd     (w_cmd_in)
    );

    sad_fifo #(
        .W($bits(t_cmd))
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cmd_push),
        .i_data (w_cmd_in),
        .o_full (w_cmd_full),
        .i_pop  (w_cmd_pop),
        .o_data (w_cmd_out),
        .o_empty(w_cmd_empty)
    );

    sad_back #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_FRAMES (NUM_FRAMES),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd_out),
        .i_cmd_empty(w_cmd_empty),
        .o_cmd_pop  (w_cmd_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    sad_fifo #(
        .W($bits(t_result))
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );

endmodule

// ===== sv/sad_checker.sv =====
`timescale 1ns / 1ps
// sad_checker: port-level assertions for the slot allocator, bound to the top
// depends on sad_pkg for the item, result and status types

module sad_checker
    import sad_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input t_item   i_item,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // nothing waits on the result side right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // an empty stack reports no handle and a zero count
    a_empty_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == ST_EMPTY) |->
            (o_result.slot_out == '0 && o_result.free_count == '0))
        else $error("empty status with handle or nonzero count");

    // only a successful allocate hands out a nonzero handle
    a_slot_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_OK) |-> o_result.slot_out == '0)
        else $error("handle returned with error status");

    // a waiting result beat holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind slot_allocator_deferred_release sad_checker u_chk (.*);
